/* sv/u8_max_pool_clamp_top_defines.svh */
// ----------------------------------------------------------------------------
// u8_max_pool_clamp_top_defines.svh
// Assertion helpers for the max pool block. Each helper expects signals named
// clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef U8_MAX_POOL_CLAMP_TOP_DEFINES_SVH
`define U8_MAX_POOL_CLAMP_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define U8MPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define U8MPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/u8mpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8mpc_pkg
// Shared widths, register indexes and helper functions for the max pool block.
// ----------------------------------------------------------------------------
package u8mpc_pkg;

    // Number of active lanes and accumulator groups.
    localparam int LANES      = 8;
    localparam int MAX_GROUPS = 64;

    // Fixed field widths.
    localparam int BYTE_W     = 8;
    localparam int FIELD_LANES = 8;
    localparam int GROUP_W    = 6;
    localparam int GROUP_CNT  = 1 << GROUP_W;

    // Derived widths.
    localparam int STORE_W = LANES * BYTE_W;
    localparam int SLOT_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_OUT_MIN = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_OUT_MAX = 1'b1;

    // Reset values of the clamp bounds.
    localparam logic [BYTE_W-1:0] OUT_MIN_RST = 8'd0;
    localparam logic [BYTE_W-1:0] OUT_MAX_RST = 8'd255;

    // Clamp bounds handed to every lane.
    typedef struct packed {
        logic [BYTE_W-1:0] out_min;
        logic [BYTE_W-1:0] out_max;
    } clamp_cfg_t;

    // Maps a group index onto its accumulator slot (group modulo MAX_GROUPS).
    // The loop runs over constants only and reduces to a small lookup table.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [GROUP_W-1:0] grp);
        logic [SLOT_W-1:0] slot;
        slot = '0;
        for (int i = 0; i < GROUP_CNT; i++)
        begin
            if (grp == GROUP_W'(i))
            begin
                slot = SLOT_W'(i % MAX_GROUPS);
            end
        end
        return slot;
    endfunction

endpackage

/* sv/u8mpc_tap_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8mpc_tap_if
// Input channel: one pooling-window tap for a group of eight channels.
// ----------------------------------------------------------------------------
interface u8mpc_tap_if
    import u8mpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  tap_lane_0;
    logic [BYTE_W-1:0]  tap_lane_1;
    logic [BYTE_W-1:0]  tap_lane_2;
    logic [BYTE_W-1:0]  tap_lane_3;
    logic [BYTE_W-1:0]  tap_lane_4;
    logic [BYTE_W-1:0]  tap_lane_5;
    logic [BYTE_W-1:0]  tap_lane_6;
    logic [BYTE_W-1:0]  tap_lane_7;
    logic [GROUP_W-1:0] group_index;
    logic               first_tap;
    logic               last_tap;

    modport source (
        output valid, tap_lane_0, tap_lane_1, tap_lane_2, tap_lane_3,
               tap_lane_4, tap_lane_5, tap_lane_6, tap_lane_7,
               group_index, first_tap, last_tap,
        input  ready
    );

    modport sink (
        input  valid, tap_lane_0, tap_lane_1, tap_lane_2, tap_lane_3,
               tap_lane_4, tap_lane_5, tap_lane_6, tap_lane_7,
               group_index, first_tap, last_tap,
        output ready
    );
endinterface

/* sv/u8mpc_pool_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8mpc_pool_if
// Output channel: clamped window maxima for one group of eight channels.
// ----------------------------------------------------------------------------
interface u8mpc_pool_if
    import u8mpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  pool_lane_0;
    logic [BYTE_W-1:0]  pool_lane_1;
    logic [BYTE_W-1:0]  pool_lane_2;
    logic [BYTE_W-1:0]  pool_lane_3;
    logic [BYTE_W-1:0]  pool_lane_4;
    logic [BYTE_W-1:0]  pool_lane_5;
    logic [BYTE_W-1:0]  pool_lane_6;
    logic [BYTE_W-1:0]  pool_lane_7;
    logic [GROUP_W-1:0] result_group;

    modport source (
        output valid, pool_lane_0, pool_lane_1, pool_lane_2, pool_lane_3,
               pool_lane_4, pool_lane_5, pool_lane_6, pool_lane_7, result_group,
        input  ready
    );

    modport sink (
        input  valid, pool_lane_0, pool_lane_1, pool_lane_2, pool_lane_3,
               pool_lane_4, pool_lane_5, pool_lane_6, pool_lane_7, result_group,
        output ready
    );
endinterface

/* sv/u8mpc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8mpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module u8mpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; a read and a write to the same entry return the old word.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/u8mpc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8mpc_lane
// One channel lane: running byte maximum followed by the output clamp.
// ----------------------------------------------------------------------------
module u8mpc_lane
    import u8mpc_pkg::*;
(
    input  logic [BYTE_W-1:0] tap,
    input  logic [BYTE_W-1:0] old,
    input  logic              first,
    input  clamp_cfg_t        cfg,
    output logic [BYTE_W-1:0] merged,
    output logic [BYTE_W-1:0] pooled
);

    logic [BYTE_W-1:0] upper;

    // A first tap restarts the window; otherwise keep the larger byte.
    assign merged = (first || (tap > old)) ? tap : old;

    // Clamp against the upper bound first, then the lower bound, so that
    // inverted bounds yield the lower bound.
    assign upper  = (merged < cfg.out_max) ? merged : cfg.out_max;
    assign pooled = (upper > cfg.out_min) ? upper : cfg.out_min;

endmodule

/* sv/u8_max_pool_clamp_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8_max_pool_clamp_top
// Unsigned 8-bit max pooling over eight parallel lanes with an output clamp.
//
//   Channel   Dir   Carries
//   tap       in    one window tap: eight bytes, group, first and last flags
//   pool      out   eight clamped maxima and the group they belong to
//   apb       in    writes and reads of out_min and out_max
//
// One word is accepted per cycle. A tap reads its group's running maximum
// from the RAM in the accept cycle and merges and writes it back as it
// leaves the merge stage, with a bypass for a back-to-back tap on the same
// group. A result is loaded into the output register as its last tap leaves
// the merge stage. Only a last tap waiting on a full, stalled output
// register holds the input. The RAM needs no clearing after reset; the user
// must see that an entry is loaded by a first tap; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "u8_max_pool_clamp_top_defines.svh"

module u8_max_pool_clamp_top
    import u8mpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    u8mpc_tap_if.sink             tap,
    u8mpc_pool_if.source          pool,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers.
    logic [BYTE_W-1:0] out_min_reg;
    logic [BYTE_W-1:0] out_max_reg;
    logic              cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;
    clamp_cfg_t        clamp_cfg;

    // Input unpacking and handshake.
    logic [BYTE_W-1:0] tap_byte [FIELD_LANES];
    logic              tap_acc;

    // Merge stage.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [BYTE_W-1:0]  s1_taps_reg [LANES];
    logic [GROUP_W-1:0] s1_group_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic               s1_first_reg;
    logic               s1_last_reg;
    logic               s1_adv;

    // Accumulator store and bypass.
    logic [STORE_W-1:0] ram_rdata;
    logic [STORE_W-1:0] old_word;
    logic [STORE_W-1:0] merged_word;
    logic               fwd_valid_reg;
    logic [SLOT_W-1:0]  fwd_slot_reg;
    logic [STORE_W-1:0] fwd_data_reg;
    logic               fwd_hit;

    // Lane results.
    logic [BYTE_W-1:0]  lane_pooled [FIELD_LANES];

    // Output register.
    logic               pool_valid_reg;
    logic               pool_valid_next;
    logic               pool_free;
    logic [BYTE_W-1:0]  pool_lanes_reg [FIELD_LANES];
    logic [GROUP_W-1:0] pool_group_reg;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // Registers sit on 4-byte boundaries; the low address bits are ignored.
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg <= OUT_MIN_RST;
            out_max_reg <= OUT_MAX_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_OUT_MIN: out_min_reg <= pwdata[BYTE_W-1:0];
                REG_OUT_MAX: out_max_reg <= pwdata[BYTE_W-1:0];
                default:     out_max_reg <= out_max_reg;
            endcase
        end
    end

    // Read data is zero-extended to the bus width.
    always_comb
    begin
        case (cfg_idx)
            REG_OUT_MIN: prdata = APB_DATA_W'(out_min_reg);
            REG_OUT_MAX: prdata = APB_DATA_W'(out_max_reg);
            default:     prdata = '0;
        endcase
    end

    assign clamp_cfg.out_min = out_min_reg;
    assign clamp_cfg.out_max = out_max_reg;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------

    // A non-last tap always moves on; a last tap needs room in the output.
    assign pool_free = !pool_valid_reg || pool.ready;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || pool_free);
    assign tap.ready = !s1_valid_reg || s1_adv;
    assign tap_acc   = tap.valid && tap.ready;

    assign tap_byte[0] = tap.tap_lane_0;
    assign tap_byte[1] = tap.tap_lane_1;
    assign tap_byte[2] = tap.tap_lane_2;
    assign tap_byte[3] = tap.tap_lane_3;
    assign tap_byte[4] = tap.tap_lane_4;
    assign tap_byte[5] = tap.tap_lane_5;
    assign tap_byte[6] = tap.tap_lane_6;
    assign tap_byte[7] = tap.tap_lane_7;

    // ------------------------------------------------------------------------
    // Merge stage registers
    // ------------------------------------------------------------------------

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tap_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_acc)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                s1_taps_reg[k] <= tap_byte[k];
            end
            s1_group_reg <= tap.group_index;
            s1_slot_reg  <= slot_of(tap.group_index);
            s1_first_reg <= tap.first_tap;
            s1_last_reg  <= tap.last_tap;
        end
    end

    // ------------------------------------------------------------------------
    // Accumulator store
    // ------------------------------------------------------------------------

    u8mpc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_GROUPS)
    ) u_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_slot_reg),
        .wdata (merged_word),
        .re    (tap_acc),
        .raddr (slot_of(tap.group_index)),
        .rdata (ram_rdata)
    );

    // The bypass holds the most recent write. It equals the stored entry for
    // its slot, and covers the read that coincided with that write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            fwd_slot_reg <= s1_slot_reg;
            fwd_data_reg <= merged_word;
        end
    end

    assign fwd_hit  = fwd_valid_reg && (fwd_slot_reg == s1_slot_reg);
    assign old_word = fwd_hit ? fwd_data_reg : ram_rdata;

    // ------------------------------------------------------------------------
    // Lanes
    // ------------------------------------------------------------------------

    for (genvar k = 0; k < FIELD_LANES; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_active
            u8mpc_lane u_lane (
                .tap    (s1_taps_reg[k]),
                .old    (old_word[k*BYTE_W +: BYTE_W]),
                .first  (s1_first_reg),
                .cfg    (clamp_cfg),
                .merged (merged_word[k*BYTE_W +: BYTE_W]),
                .pooled (lane_pooled[k])
            );
        end
        else
        begin : g_unused
            // Lanes past the configured count report zero.
            assign lane_pooled[k] = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Output register: gathers the lane results into one word
    // ------------------------------------------------------------------------

    always_comb
    begin
        pool_valid_next = pool_valid_reg;
        if (s1_adv && s1_last_reg)
        begin
            pool_valid_next = 1'b1;
        end
        else if (pool.ready)
        begin
            pool_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_valid_reg <= 1'b0;
        end
        else
        begin
            pool_valid_reg <= pool_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            for (int k = 0; k < FIELD_LANES; k++)
            begin
                pool_lanes_reg[k] <= lane_pooled[k];
            end
            pool_group_reg <= s1_group_reg;
        end
    end

    assign pool.valid        = pool_valid_reg;
    assign pool.pool_lane_0  = pool_lanes_reg[0];
    assign pool.pool_lane_1  = pool_lanes_reg[1];
    assign pool.pool_lane_2  = pool_lanes_reg[2];
    assign pool.pool_lane_3  = pool_lanes_reg[3];
    assign pool.pool_lane_4  = pool_lanes_reg[4];
    assign pool.pool_lane_5  = pool_lanes_reg[5];
    assign pool.pool_lane_6  = pool_lanes_reg[6];
    assign pool.pool_lane_7  = pool_lanes_reg[7];
    assign pool.result_group = pool_group_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A last tap leaving the merge stage always lands in the output register.
    `U8MPC_ASSERT_NEXT(a_last_emits, s1_adv && s1_last_reg, pool_valid_reg,
                       "last tap lost")

    // A last tap must not overwrite a result that is still waiting.
    `U8MPC_ASSERT_SAME(a_no_overrun,
                       pool_valid_reg && !pool.ready && s1_valid_reg && s1_last_reg,
                       !s1_adv, "result overwritten")

    // The bypass tracks the slot that was just written.
    `U8MPC_ASSERT_NEXT(a_fwd_track, s1_adv,
                       fwd_valid_reg && (fwd_slot_reg == $past(s1_slot_reg)),
                       "bypass slot mismatch")

    // An empty merge stage never holds off the input.
    `U8MPC_ASSERT_SAME(a_ready_empty, !s1_valid_reg, tap.ready, "input stalled while empty")

endmodule

/* tb/u8_max_pool_clamp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8_max_pool_clamp_checker
// Watches the tap, pool and register ports of the max pool block. It keeps
// its own copy of the clamp bounds and of every group's running maxima. It
// predicts the pooled word for each accepted last tap and compares every
// accepted pool word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module u8_max_pool_clamp_checker
    import u8mpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    u8mpc_tap_if                  tap,
    u8mpc_pool_if                 pool,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    errors,
    output int                    pending
);

    typedef logic [LANES-1:0][BYTE_W-1:0] lane_bytes_t;

    typedef struct packed {
        lane_bytes_t        lanes;
        logic [GROUP_W-1:0] grp;
    } pooled_word_t;

    // Clamp bounds as last written through the register port.
    logic [BYTE_W-1:0] clamp_lo;
    logic [BYTE_W-1:0] clamp_hi;

    // Running maxima per accumulator slot, and the pooled words still owed.
    lane_bytes_t  window_max [MAX_GROUPS];
    pooled_word_t pooled_due [$];

    // Counts one failure and reports it while the report budget lasts.
    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    // Folds one tap into its group and returns the clamped word it would emit.
    function automatic pooled_word_t fold_tap(input lane_bytes_t taps,
                                              input logic [GROUP_W-1:0] grp,
                                              input logic first);
        int           slot;
        lane_bytes_t  merged;
        logic [7:0]   v;
        pooled_word_t res;
        slot = int'(grp) % MAX_GROUPS;
        for (int k = 0; k < LANES; k++)
        begin
            if (first || taps[k] > window_max[slot][k])
            begin
                merged[k] = taps[k];
            end
            else
            begin
                merged[k] = window_max[slot][k];
            end
        end
        window_max[slot] = merged;
        // Upper bound first, then lower bound, so inverted bounds give clamp_lo.
        for (int k = 0; k < LANES; k++)
        begin
            v = merged[k];
            if (v > clamp_hi)
            begin
                v = clamp_hi;
            end
            if (v < clamp_lo)
            begin
                v = clamp_lo;
            end
            res.lanes[k] = v;
        end
        res.grp = grp;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [REG_IDX_W-1:0] reg_idx;
        lane_bytes_t          taps;
        pooled_word_t         want;
        pooled_word_t         got;
        if (!rst_n)
        begin
            clamp_lo = OUT_MIN_RST;
            clamp_hi = OUT_MAX_RST;
            pooled_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // Register writes.
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = paddr[2 +: REG_IDX_W];
                if (reg_idx == REG_OUT_MIN)
                begin
                    clamp_lo = pwdata[BYTE_W-1:0];
                end
                else if (reg_idx == REG_OUT_MAX)
                begin
                    clamp_hi = pwdata[BYTE_W-1:0];
                end
            end

            // An accepted tap word updates the maxima; a last tap owes a word.
            if (tap.valid && tap.ready)
            begin
                taps = {tap.tap_lane_7, tap.tap_lane_6, tap.tap_lane_5, tap.tap_lane_4,
                        tap.tap_lane_3, tap.tap_lane_2, tap.tap_lane_1, tap.tap_lane_0};
                want = fold_tap(taps, tap.group_index, tap.first_tap);
                if (tap.last_tap)
                begin
                    pooled_due.push_back(want);
                end
            end

            // An accepted pool word is checked against the oldest one owed.
            if (pool.valid && pool.ready)
            begin
                got.lanes = {pool.pool_lane_7, pool.pool_lane_6, pool.pool_lane_5,
                             pool.pool_lane_4, pool.pool_lane_3, pool.pool_lane_2,
                             pool.pool_lane_1, pool.pool_lane_0};
                got.grp = pool.result_group;
                if (pooled_due.size() == 0)
                begin
                    note_failure($sformatf("unexpected pool word, group %0d", got.grp));
                end
                else
                begin
                    want = pooled_due.pop_front();
                    for (int k = 0; k < LANES; k++)
                    begin
                        if (got.lanes[k] !== want.lanes[k])
                        begin
                            note_failure($sformatf("group %0d lane %0d expected %0d got %0d",
                                                   want.grp, k, want.lanes[k],
                                                   got.lanes[k]));
                        end
                    end
                    if (got.grp !== want.grp)
                    begin
                        note_failure($sformatf("result_group expected %0d got %0d",
                                               want.grp, got.grp));
                    end
                end
            end
            pending = pooled_due.size();
        end
    end

endmodule

/* tb/u8_max_pool_clamp_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8_max_pool_clamp_top_tb
// Drives the max pool block with directed taps and then with random pooling
// windows over interleaved groups, under several clamp settings and idle
// patterns, including one long output stall. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module u8_max_pool_clamp_top_tb;
    import u8mpc_pkg::*;

    localparam int HOLD_LEN       = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int PHASE_TAPS     = 250;
    localparam int RANDOM_PHASES  = 8;

    typedef struct packed {
        logic [LANES-1:0][BYTE_W-1:0] lanes;
        logic [GROUP_W-1:0]           grp;
        logic                         first;
        logic                         last;
    } tap_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    chk_errors;
    int                    pending;

    // Idle controls, in percent per cycle, and the long-stall request.
    int send_idle_pct;
    int stall_pct;
    bit hold_request;

    // Groups loaded by a first tap since reset; only these may accumulate.
    bit loaded [MAX_GROUPS];
    int taps_sent;

    u8mpc_tap_if  tap_ch ();
    u8mpc_pool_if pool_ch ();

    u8_max_pool_clamp_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .tap     (tap_ch),
        .pool    (pool_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    u8_max_pool_clamp_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .tap     (tap_ch),
        .pool    (pool_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .errors  (chk_errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    initial
    begin
        pool_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                pool_ch.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_request = 1'b0;
            end
            pool_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one tap word after random idle cycles and waits for acceptance.
    task automatic push_tap(input tap_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tap_ch.valid = 1'b0;
            @(negedge clk);
        end
        tap_ch.tap_lane_0  = w.lanes[0];
        tap_ch.tap_lane_1  = w.lanes[1];
        tap_ch.tap_lane_2  = w.lanes[2];
        tap_ch.tap_lane_3  = w.lanes[3];
        tap_ch.tap_lane_4  = w.lanes[4];
        tap_ch.tap_lane_5  = w.lanes[5];
        tap_ch.tap_lane_6  = w.lanes[6];
        tap_ch.tap_lane_7  = w.lanes[7];
        tap_ch.group_index = w.grp;
        tap_ch.first_tap   = w.first;
        tap_ch.last_tap    = w.last;
        tap_ch.valid       = 1'b1;
        @(posedge clk);
        while (!tap_ch.ready)
        begin
            @(posedge clk);
        end
        if (w.first)
        begin
            loaded[w.grp] = 1'b1;
        end
        taps_sent++;
    endtask

    // Builds and sends one tap word with the same byte in every lane.
    task automatic push_flat(input logic [7:0] b, input int grp, input bit first,
                             input bit last);
        tap_word_t w;
        w.lanes = {LANES{b}};
        w.grp   = GROUP_W'(grp);
        w.first = first;
        w.last  = last;
        push_tap(w);
    endtask

    // Random lane bytes, leaning toward the two extremes now and then.
    function automatic logic [LANES-1:0][BYTE_W-1:0] random_lanes();
        logic [LANES-1:0][BYTE_W-1:0] l;
        int                           pick;
        for (int k = 0; k < LANES; k++)
        begin
            pick = $urandom_range(7);
            if (pick == 0)
            begin
                l[k] = 8'd0;
            end
            else if (pick == 1)
            begin
                l[k] = 8'd255;
            end
            else
            begin
                l[k] = 8'($urandom_range(255));
            end
        end
        return l;
    endfunction

    // Lets the block drain, then waits out its pipeline before a register write.
    task automatic settle();
        int guard;
        guard = 0;
        @(negedge clk);
        tap_ch.valid = 1'b0;
        while ((pending != 0 || hold_request) && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_clamp(input logic [7:0] lo, input logic [7:0] hi,
                             input bit junk_upper);
        logic [APB_DATA_W-1:0] upper;
        upper = junk_upper ? ($urandom() & ~APB_DATA_W'(8'hFF)) : '0;
        settle();
        reg_write(REG_OUT_MIN, upper | APB_DATA_W'(lo));
        reg_write(REG_OUT_MAX, upper | APB_DATA_W'(hi));
    endtask

    // A set of windows over a few groups, taps interleaved across the groups.
    task automatic push_windows(input int n_groups, input int len);
        int        grps [4];
        bit        dup;
        tap_word_t w;
        for (int g = 0; g < n_groups; g++)
        begin
            do
            begin
                grps[g] = $urandom_range(MAX_GROUPS - 1);
                dup = 1'b0;
                for (int j = 0; j < g; j++)
                begin
                    if (grps[j] == grps[g])
                    begin
                        dup = 1'b1;
                    end
                end
            end
            while (dup);
        end
        for (int t = 0; t < len; t++)
        begin
            for (int g = 0; g < n_groups; g++)
            begin
                w.lanes = random_lanes();
                w.grp   = GROUP_W'(grps[g]);
                w.first = (t == 0);
                w.last  = (t == len - 1);
                push_tap(w);
            end
        end
    endtask

    // A stray tap with random flags; an unloaded group always restarts.
    task automatic push_stray();
        tap_word_t w;
        w.lanes = random_lanes();
        w.grp   = GROUP_W'($urandom_range(MAX_GROUPS - 1));
        w.first = 1'($urandom_range(1));
        w.last  = 1'($urandom_range(1));
        if (!loaded[w.grp])
        begin
            w.first = 1'b1;
        end
        push_tap(w);
    endtask

    initial
    begin : stimulus
        tap_word_t   w;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int          target;
        int          guard;

        // Every input known from time zero.
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tap_ch.valid    = 1'b0;
        tap_ch.tap_lane_0 = '0;
        tap_ch.tap_lane_1 = '0;
        tap_ch.tap_lane_2 = '0;
        tap_ch.tap_lane_3 = '0;
        tap_ch.tap_lane_4 = '0;
        tap_ch.tap_lane_5 = '0;
        tap_ch.tap_lane_6 = '0;
        tap_ch.tap_lane_7 = '0;
        tap_ch.group_index = '0;
        tap_ch.first_tap  = 1'b0;
        tap_ch.last_tap   = 1'b0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_request    = 1'b0;
        taps_sent       = 0;
        for (int g = 0; g < MAX_GROUPS; g++)
        begin
            loaded[g] = 1'b0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-tap windows at the byte and group extremes.
        push_flat(8'd255, 0, 1'b1, 1'b1);
        push_flat(8'd0, MAX_GROUPS - 1, 1'b1, 1'b1);
        push_flat(8'hAA, 1, 1'b1, 1'b1);
        push_flat(8'h55, 2, 1'b1, 1'b1);

        // A window on one group with lanes rising and falling between taps.
        w.grp = 6'd5;
        w.first = 1'b1;
        w.last = 1'b0;
        w.lanes = {8'd80, 8'd70, 8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'd10};
        push_tap(w);
        w.first = 1'b0;
        w.lanes = {8'd1, 8'd2, 8'd200, 8'd4, 8'd255, 8'd6, 8'd7, 8'd0};
        push_tap(w);
        w.last = 1'b1;
        w.lanes = {8'd90, 8'd0, 8'd0, 8'd100, 8'd0, 8'd31, 8'd0, 8'd11};
        push_tap(w);

        // Back-to-back taps on one group, and a window left open for a while.
        push_flat(8'd3, 7, 1'b1, 1'b0);
        push_flat(8'd9, 9, 1'b1, 1'b0);
        push_flat(8'd254, 7, 1'b0, 1'b0);
        push_flat(8'd1, 7, 1'b0, 1'b1);
        push_flat(8'd8, 9, 1'b0, 1'b1);

        // Clamp with a narrow range: values below, inside and above it.
        set_clamp(8'h30, 8'hD0, 1'b0);
        push_flat(8'h10, 11, 1'b1, 1'b1);
        push_flat(8'h80, 12, 1'b1, 1'b1);
        push_flat(8'hF0, 13, 1'b1, 1'b1);
        w.grp = 6'd14;
        w.first = 1'b1;
        w.last = 1'b1;
        w.lanes = {8'hFF, 8'hD1, 8'hD0, 8'h80, 8'h30, 8'h2F, 8'h01, 8'h00};
        push_tap(w);

        // Inverted bounds: every lane comes out as the lower bound.
        set_clamp(8'd200, 8'd50, 1'b0);
        push_tap(w);
        push_flat(8'd0, 15, 1'b1, 1'b1);
        push_flat(8'd255, 16, 1'b1, 1'b1);

        // Random windows under a series of clamp settings and idle patterns.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: begin lo = 8'd0;   hi = 8'd255; end
                1: begin lo = 8'h40;  hi = 8'hC0;  end
                2: begin lo = 8'd200; hi = 8'd50;  end
                3: begin lo = 8'd0;   hi = 8'd0;   end
                4: begin lo = 8'd255; hi = 8'd255; end
                7: begin lo = 8'd0;   hi = 8'd255; end
                default:
                begin
                    lo = 8'($urandom_range(127));
                    hi = 8'($urandom_range(255, 128));
                end
            endcase
            set_clamp(lo, hi, 1'b1);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 51; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 25; stall_pct = 25; end
            endcase
            // Long output stall while taps keep coming, to fill the block.
            if (p == 4)
            begin
                hold_request = 1'b1;
            end
            target = taps_sent + PHASE_TAPS;
            while (taps_sent < target)
            begin
                if ($urandom_range(99) < 80)
                begin
                    push_windows($urandom_range(4, 1), $urandom_range(9, 1));
                end
                else
                begin
                    push_stray();
                end
            end
        end

        // Drain, then a short tail for anything still in flight.
        @(negedge clk);
        tap_ch.valid = 1'b0;
        stall_pct = 0;
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);

        if (chk_errors == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
